[hdl/pcss_pkg.sv]
// Shared types and constants for the proximity calibrate and speed select block.
// Holds opcode, motor command and register index codes, the config and result
// structs, and the controller/datapath handshake structs. No dependencies.
package pcss_pkg;

    // Input opcodes
    localparam logic [2:0] OP_SAMPLE     = 3'd0;
    localparam logic [2:0] OP_CAL_REQ    = 3'd1;
    localparam logic [2:0] OP_JOY_OTHER  = 3'd2;
    localparam logic [2:0] OP_DM_PRESS   = 3'd3;
    localparam logic [2:0] OP_DM_RELEASE = 3'd4;

    // Motor commands
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_SET_SPEED = 3'd1;
    localparam logic [2:0] CMD_STOP_MOVE = 3'd2;
    localparam logic [2:0] CMD_TRAVERSE  = 3'd3;
    localparam logic [2:0] CMD_STOP      = 3'd4;
    localparam logic [2:0] CMD_ENABLE    = 3'd5;

    // Register map (index = byte address / 4)
    localparam int ADDR_BITS    = 5;
    localparam int REG_IDX_BITS = 3;
    localparam logic [REG_IDX_BITS-1:0] REG_STOPPING_DISTANCE = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_HIGH_SPEED        = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SLOW_SPEED        = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_NEAR_POSITION     = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_FAR_POSITION      = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_TRAVERSE_DISTANCE = 3'd5;

    // Register reset values
    localparam logic [14:0] STOPPING_DISTANCE_RST = 15'd100;
    localparam logic [14:0] HIGH_SPEED_RST        = 15'd2000;
    localparam logic [14:0] SLOW_SPEED_RST        = 15'd500;
    localparam logic signed [15:0] NEAR_POSITION_RST = 16'sd70;
    localparam logic signed [15:0] FAR_POSITION_RST  = 16'sd500;
    localparam logic [14:0] TRAVERSE_DISTANCE_RST = 15'd600;

    // Number of light reading fields on the input port
    localparam int LIGHT_FIELDS = 3;
    localparam int LIGHT_BITS   = 12;

    typedef struct packed {
        logic [14:0]        stopping_distance;
        logic [14:0]        high_speed;
        logic [14:0]        slow_speed;
        logic signed [15:0] near_position;
        logic signed [15:0] far_position;
        logic [14:0]        traverse_distance;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         motor_cmd;
        logic signed [15:0] speed_value;
        logic [14:0]        move_distance;
        logic               calibrating_now;
        logic               running_now;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic div_step;
        logic div_wb;
        logic out_load_new;
        logic skid_load_new;
        logic out_load_skid;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;
    } dp_status_t;

    // Near threshold reset value per channel; channels past the light fields read 0
    function automatic logic [LIGHT_BITS-1:0] near_reset(input int idx);
        logic [LIGHT_BITS-1:0] val;
        case (idx)
            0:       val = 12'd770;
            1:       val = 12'd634;
            2:       val = 12'd710;
            default: val = '0;
        endcase
        return val;
    endfunction

    // Far threshold reset value per channel
    function automatic logic [LIGHT_BITS-1:0] far_reset(input int idx);
        logic [LIGHT_BITS-1:0] val;
        case (idx)
            0:       val = 12'd48;
            1:       val = 12'd36;
            2:       val = 12'd43;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[hdl/pcss_regs.sv]
// APB-style configuration register file for the speed select block.
// Depends on pcss_pkg for the register map, reset values and cfg_t.
module pcss_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcss_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output pcss_pkg::cfg_t                 cfg
);

    pcss_pkg::cfg_t cfg_reg;
    pcss_pkg::cfg_t cfg_next;
    logic [pcss_pkg::REG_IDX_BITS-1:0] reg_idx;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[pcss_pkg::ADDR_BITS-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                pcss_pkg::REG_STOPPING_DISTANCE: cfg_next.stopping_distance = pwdata[14:0];
                pcss_pkg::REG_HIGH_SPEED:        cfg_next.high_speed        = pwdata[14:0];
                pcss_pkg::REG_SLOW_SPEED:        cfg_next.slow_speed        = pwdata[14:0];
                pcss_pkg::REG_NEAR_POSITION:     cfg_next.near_position     = pwdata[15:0];
                pcss_pkg::REG_FAR_POSITION:      cfg_next.far_position      = pwdata[15:0];
                pcss_pkg::REG_TRAVERSE_DISTANCE: cfg_next.traverse_distance = pwdata[14:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stopping_distance <= pcss_pkg::STOPPING_DISTANCE_RST;
            cfg_reg.high_speed        <= pcss_pkg::HIGH_SPEED_RST;
            cfg_reg.slow_speed        <= pcss_pkg::SLOW_SPEED_RST;
            cfg_reg.near_position     <= pcss_pkg::NEAR_POSITION_RST;
            cfg_reg.far_position      <= pcss_pkg::FAR_POSITION_RST;
            cfg_reg.traverse_distance <= pcss_pkg::TRAVERSE_DISTANCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back; positions are sign extended
    always_comb
    begin
        case (reg_idx)
            pcss_pkg::REG_STOPPING_DISTANCE: prdata = {17'd0, cfg_reg.stopping_distance};
            pcss_pkg::REG_HIGH_SPEED:        prdata = {17'd0, cfg_reg.high_speed};
            pcss_pkg::REG_SLOW_SPEED:        prdata = {17'd0, cfg_reg.slow_speed};
            pcss_pkg::REG_NEAR_POSITION:
                prdata = {{16{cfg_reg.near_position[15]}}, cfg_reg.near_position};
            pcss_pkg::REG_FAR_POSITION:
                prdata = {{16{cfg_reg.far_position[15]}}, cfg_reg.far_position};
            pcss_pkg::REG_TRAVERSE_DISTANCE: prdata = {17'd0, cfg_reg.traverse_distance};
            default:                         prdata = '0;
        endcase
    end

endmodule

[hdl/pcss_ctrl.sv]
// Controller for the speed select block: request handshake, divider sequencing
// and the two-entry result buffer. Depends on pcss_pkg for the command structs.
module pcss_ctrl #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  pcss_pkg::dp_status_t    status,
    output pcss_pkg::ctrl_cmd_t     cmd
);

    localparam int STEP_BITS = $clog2(SAMPLE_BITS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(SAMPLE_BITS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic                 accept;
    logic                 take;

    // Take a request only when idle and the skid slot is free
    assign in_ready  = (state_reg == ST_IDLE) && !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign take      = out_valid_reg && out_ready;

    always_comb
    begin
        cmd               = '0;
        cmd.accept        = accept;
        cmd.div_step      = (state_reg == ST_DIV);
        cmd.div_wb        = (state_reg == ST_WB);
        cmd.out_load_new  = accept && (!out_valid_reg || take);
        cmd.skid_load_new = accept && out_valid_reg && !take;
        cmd.out_load_skid = !accept && take && skid_valid_reg;
    end

    // Result buffer occupancy
    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (take)
            out_valid_next = skid_valid_reg;
        else
            out_valid_next = out_valid_reg;

        if (skid_valid_reg)
            skid_valid_next = !take;
        else
            skid_valid_next = accept && out_valid_reg && !take;
    end

    // Sequence the divider
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.need_div)
                begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV:
            begin
                if (step_reg == LAST_STEP)
                    state_next = ST_WB;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_WB:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Skid slot is only used behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // No request taken while the divider owns the state
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("request accepted during division");

    // A capturing request starts the divider at step zero
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.need_div) |=> (state_reg == ST_DIV && step_reg == '0))
        else $error("divider did not start");

    // The last step hands over to writeback
    a_div_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && step_reg == LAST_STEP) |=> (state_reg == ST_WB))
        else $error("divider did not finish");

    // Every accepted request leaves a result behind
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted request produced no result");

endmodule

[hdl/pcss_dp.sv]
// Datapath for the speed select block: mode flags, per-channel sums and
// thresholds, one restoring divider lane per channel, and the result buffer.
// Depends on pcss_pkg for codes, cfg_t, result_t and the command structs.
module pcss_dp #(
    parameter int CHANNELS    = 3,
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [2:0]                 opcode,
    input  logic [11:0]                light_left,
    input  logic [11:0]                light_middle,
    input  logic [11:0]                light_right,
    input  logic signed [15:0]         wheel_position,
    input  logic                       at_target,
    input  pcss_pkg::cfg_t             cfg,
    input  pcss_pkg::ctrl_cmd_t        cmd,
    output pcss_pkg::dp_status_t       status,
    output pcss_pkg::result_t          result
);

    localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;
    localparam int FIELD_BITS = (SAMPLE_BITS < pcss_pkg::LIGHT_BITS) ?
                                SAMPLE_BITS : pcss_pkg::LIGHT_BITS;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic signed [15:0]    last_pos_reg, last_pos_next;
    logic                  cal_reg, cal_next;
    logic                  run_reg, run_next;
    logic [14:0]           speed_reg, speed_next;
    logic [COUNT_BITS-1:0] divisor_reg, divisor_next;
    logic                  div_zero_reg, div_zero_next;
    logic                  cap_near_reg, cap_near_next;
    pcss_pkg::result_t     out_reg, out_next;
    pcss_pkg::result_t     skid_reg, skid_next;
    pcss_pkg::result_t     res_new;

    logic [CHANNELS-1:0]   below_far;
    logic [CHANNELS-1:0]   below_near;
    logic                  pos_same;
    logic                  last_is_near;
    logic                  last_is_far;
    logic                  count_full;
    logic                  sample_acc;
    logic                  add_sample;
    logic                  close_pos;
    logic                  load_div;

    assign pos_same     = (wheel_position == last_pos_reg);
    assign last_is_near = (last_pos_reg == cfg.near_position);
    assign last_is_far  = (last_pos_reg == cfg.far_position);
    assign count_full   = &count_reg;

    // Capture needs calibration still on after the at-target check
    assign status.need_div = (opcode == pcss_pkg::OP_SAMPLE) && cal_reg && !at_target &&
                             !pos_same && (last_is_near || last_is_far);

    assign sample_acc = cmd.accept && (opcode == pcss_pkg::OP_SAMPLE) && cal_reg;
    assign add_sample = sample_acc && pos_same && !count_full;
    assign close_pos  = sample_acc && !pos_same;
    assign load_div   = cmd.accept && status.need_div;

    // Per-channel lanes: reading, thresholds, sum and divider
    genvar i;
    for (i = 0; i < CHANNELS; i++)
    begin : g_lane
        logic [SAMPLE_BITS-1:0] rd;
        logic [SAMPLE_BITS-1:0] near_thr_reg, near_thr_next;
        logic [SAMPLE_BITS-1:0] far_thr_reg, far_thr_next;
        logic [SUM_BITS-1:0]    sum_reg, sum_next;
        logic [COUNT_BITS-1:0]  rem_reg, rem_next;
        logic [SAMPLE_BITS-1:0] quo_reg, quo_next;
        logic [COUNT_BITS:0]    trial;
        logic [COUNT_BITS:0]    trial_diff;
        logic                   fits;
        logic [SAMPLE_BITS-1:0] avg;

        if (i == 0)
        begin : g_left
            assign rd = SAMPLE_BITS'(light_left[FIELD_BITS-1:0]);
        end
        else if (i == 1)
        begin : g_middle
            assign rd = SAMPLE_BITS'(light_middle[FIELD_BITS-1:0]);
        end
        else if (i == 2)
        begin : g_right
            assign rd = SAMPLE_BITS'(light_right[FIELD_BITS-1:0]);
        end
        else
        begin : g_none
            assign rd = '0;
        end

        assign below_far[i]  = (rd < far_thr_reg);
        assign below_near[i] = (rd < near_thr_reg);

        // One restoring step: shift in the next dividend bit, subtract if it fits
        assign trial      = {rem_reg, quo_reg[SAMPLE_BITS-1]};
        assign trial_diff = trial - {1'b0, divisor_reg};
        assign fits       = (trial >= {1'b0, divisor_reg});
        assign avg        = div_zero_reg ? '0 : quo_reg;

        always_comb
        begin
            sum_next      = sum_reg;
            rem_next      = rem_reg;
            quo_next      = quo_reg;
            near_thr_next = near_thr_reg;
            far_thr_next  = far_thr_reg;

            if (add_sample)
                sum_next = sum_reg + SUM_BITS'(rd);
            else if (close_pos)
                sum_next = '0;

            // Quotient fits the sample width, so the high part starts below the divisor
            if (load_div)
            begin
                rem_next = sum_reg[SUM_BITS-1:SAMPLE_BITS];
                quo_next = sum_reg[SAMPLE_BITS-1:0];
            end
            else if (cmd.div_step)
            begin
                rem_next = fits ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
                quo_next = {quo_reg[SAMPLE_BITS-2:0], fits};
            end

            if (cmd.div_wb)
            begin
                if (cap_near_reg)
                    near_thr_next = avg;
                else
                    far_thr_next = avg;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                near_thr_reg <= SAMPLE_BITS'(pcss_pkg::near_reset(i));
                far_thr_reg  <= SAMPLE_BITS'(pcss_pkg::far_reset(i));
                sum_reg      <= '0;
            end
            else
            begin
                near_thr_reg <= near_thr_next;
                far_thr_reg  <= far_thr_next;
                sum_reg      <= sum_next;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Decode the request into a result and the next mode flags
    always_comb
    begin
        res_new    = '0;
        cal_next   = cal_reg;
        run_next   = run_reg;
        speed_next = speed_reg;

        case (opcode)
            pcss_pkg::OP_SAMPLE:
            begin
                if (cal_reg && at_target)
                    cal_next = 1'b0;
                if (run_reg)
                begin
                    if (&below_far)
                    begin
                        speed_next          = cfg.high_speed;
                        res_new.motor_cmd   = pcss_pkg::CMD_SET_SPEED;
                        res_new.speed_value = {1'b0, cfg.high_speed};
                    end
                    else if (&below_near)
                    begin
                        speed_next          = cfg.slow_speed;
                        res_new.motor_cmd   = pcss_pkg::CMD_SET_SPEED;
                        res_new.speed_value = {1'b0, cfg.slow_speed};
                    end
                    else
                    begin
                        res_new.motor_cmd     = pcss_pkg::CMD_STOP_MOVE;
                        res_new.move_distance = cfg.stopping_distance;
                        run_next              = 1'b0;
                    end
                end
            end
            pcss_pkg::OP_CAL_REQ:
            begin
                if (!run_reg && !cal_reg)
                begin
                    cal_next              = 1'b1;
                    res_new.motor_cmd     = pcss_pkg::CMD_TRAVERSE;
                    res_new.speed_value   = 16'd0 - {1'b0, cfg.slow_speed};
                    res_new.move_distance = cfg.traverse_distance;
                end
            end
            pcss_pkg::OP_JOY_OTHER:
            begin
                if (!run_reg)
                begin
                    cal_next          = 1'b0;
                    res_new.motor_cmd = pcss_pkg::CMD_STOP;
                end
            end
            pcss_pkg::OP_DM_PRESS:
            begin
                res_new.motor_cmd   = pcss_pkg::CMD_ENABLE;
                res_new.speed_value = {1'b0, speed_reg};
                run_next            = 1'b1;
                cal_next            = 1'b0;
            end
            pcss_pkg::OP_DM_RELEASE:
            begin
                res_new.motor_cmd = pcss_pkg::CMD_STOP;
                run_next          = 1'b0;
            end
            default:
            begin
                res_new.motor_cmd = pcss_pkg::CMD_NONE;
            end
        endcase

        res_new.calibrating_now = cal_next;
        res_new.running_now     = run_next;
    end

    // Shared count, position and divider setup
    always_comb
    begin
        count_next    = count_reg;
        last_pos_next = last_pos_reg;
        divisor_next  = divisor_reg;
        div_zero_next = div_zero_reg;
        cap_near_next = cap_near_reg;

        if (add_sample)
            count_next = count_reg + 1'b1;
        else if (close_pos)
        begin
            count_next    = '0;
            last_pos_next = wheel_position;
        end

        if (load_div)
        begin
            divisor_next  = count_reg;
            div_zero_next = (count_reg == '0);
            cap_near_next = last_is_near;
        end
    end

    // Result buffer: output entry plus one skid entry
    always_comb
    begin
        if (cmd.out_load_new)
            out_next = res_new;
        else if (cmd.out_load_skid)
            out_next = skid_reg;
        else
            out_next = out_reg;

        skid_next = cmd.skid_load_new ? res_new : skid_reg;
    end

    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            last_pos_reg <= '0;
            cal_reg      <= 1'b0;
            run_reg      <= 1'b0;
            speed_reg    <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            last_pos_reg <= last_pos_next;
            if (cmd.accept)
            begin
                cal_reg   <= cal_next;
                run_reg   <= run_next;
                speed_reg <= speed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg  <= divisor_next;
        div_zero_reg <= div_zero_next;
        cap_near_reg <= cap_near_next;
        out_reg      <= out_next;
        skid_reg     <= skid_next;
    end

endmodule

[hdl/proximity_calibrate_and_speed_select.sv]
// A result is registered into the output entry when its request is taken, or into the
// skid entry if the output entry is held. One request per cycle while the skid entry is
// free, except a calibration sample that closes the near or far position: it holds the
// input until the bit-per-cycle restoring divider lanes have formed the channel averages.
// Reset (rst_n, asynchronous, active low): modes off, sums and count cleared,
// thresholds and configuration registers back to their default values.
module proximity_calibrate_and_speed_select #(
    parameter int CHANNELS    = 3,
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     opcode,
    input  logic [11:0]                    light_left,
    input  logic [11:0]                    light_middle,
    input  logic [11:0]                    light_right,
    input  logic signed [15:0]             wheel_position,
    input  logic                           at_target,
    // Result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     motor_cmd,
    output logic signed [15:0]             speed_value,
    output logic [14:0]                    move_distance,
    output logic                           calibrating_now,
    output logic                           running_now,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcss_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    pcss_pkg::cfg_t       cfg;
    pcss_pkg::ctrl_cmd_t  cmd;
    pcss_pkg::dp_status_t status;
    pcss_pkg::result_t    result;

    pcss_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcss_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pcss_dp #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .opcode         (opcode),
        .light_left     (light_left),
        .light_middle   (light_middle),
        .light_right    (light_right),
        .wheel_position (wheel_position),
        .at_target      (at_target),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .result         (result)
    );

    // Drive the result fields
    assign motor_cmd       = result.motor_cmd;
    assign speed_value     = result.speed_value;
    assign move_distance   = result.move_distance;
    assign calibrating_now = result.calibrating_now;
    assign running_now     = result.running_now;

endmodule
